// File: src/cpi_pkg.sv
// cpi_pkg: widths, relation codes and cell types for the circle pair
// intersection pipeline; no dependencies
`default_nettype none

package cpi_pkg;

   localparam int CoordW   = 24;
   localparam int RadW     = CoordW - 1;
   localparam int DiffW    = CoordW + 1;
   localparam int SqW      = 2 * DiffW;
   localparam int RootArgW = SqW;
   localparam int RootW    = RootArgW / 2;
   localparam int RootRemW = RootW + 2;
   localparam int DivQW    = CoordW + 2;
   localparam int DivDenW  = RootW + 1;
   localparam int NumW     = DivDenW + DivQW;
   localparam int ProdW    = DiffW + CoordW;
   localparam int SumW     = ProdW + 1;
   localparam int SatW     = DivQW + 2;
   localparam int TolW     = 32;
   localparam int ReqW     = 144;
   localparam int RspW     = 104;
   localparam int RelW     = 3;

   localparam int PipeDepth = 4 + RootW + 1 + DivQW + 3 + RootW + 3 + DivQW + 1;

   typedef enum logic [RelW-1:0] {
      REL_SAME,
      REL_APART,
      REL_EXT_TOUCH,
      REL_TWO_POINTS,
      REL_INT_TOUCH,
      REL_CONTAINED
   } rel_type;

   typedef struct packed {
      logic [RootArgW-1:0] arg;
      logic [RootRemW-1:0] rem;
      logic [RootW-1:0]    root;
   } root_cell_type;

   typedef struct packed {
      logic [DivDenW-1:0] rem;
      logic [DivQW-1:0]   lo;
      logic [DivDenW-1:0] den;
   } div_cell_type;

endpackage

`default_nettype wire

// File: src/circle_pair_intersection.sv
// circle_pair_intersection: classifies a pair of circles and gives their common points
// depends on cpi_pkg, cpi_root_cell, cpi_div_cell
//
//   port group  dir  contents
//   req_*       in   one circle pair per request
//   rsp_*       out  relation and up to two points per request
//   csr_*       in   touch tolerance write
//
// one request per cycle while the response is not stalled; the pipeline holds two square
// root chains of 25 cells and two divider stages of 26 cells each, plus eleven stages of
// multiply and add and the output register
// reset clears the valid bits and the tolerance register
// a stalled response holds the whole pipeline; req_tready follows rsp_tready
`default_nettype none

module circle_pair_intersection (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // first_x, first_y, first_radius, second_x, second_y, second_radius
   input  logic [cpi_pkg::ReqW-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // relation, point_a_x, point_a_y, point_b_x, point_b_y
   output logic [cpi_pkg::RspW-1:0]   rsp_tdata,
   input  logic                       csr_wr_en,
   input  logic [cpi_pkg::TolW-1:0]   csr_wr_data
);
   import cpi_pkg::*;

   typedef struct packed {
      logic signed [CoordW-1:0] x1;
      logic signed [CoordW-1:0] y1;
      logic [RadW-1:0]          r1;
      logic [RadW-1:0]          r2;
      logic signed [DiffW-1:0]  ex;
      logic signed [DiffW-1:0]  ey;
      logic [DiffW-1:0]         ax;
      logic [DiffW-1:0]         ay;
      logic [RadW:0]            rs;
      logic [RadW-1:0]          rd;
      logic                     same;
      logic [SqW-1:0]           axx;
      logic [SqW-1:0]           ayy;
      logic [SqW-1:0]           d;
      logic [2*RadW+1:0]        big_sq;
      logic [2*RadW-1:0]        small_sq;
      logic [2*RadW-1:0]        r1sq;
      logic [2*RadW-1:0]        r2sq;
      logic [2*RadW-1:0]        bsq;
      logic [2*RadW-1:0]        carg;
      rel_type                  rel;
      logic                     inner;
      logic signed [NumW-1:0]   num;
      logic [RootW-1:0]         sd;
      logic [RadW-1:0]          bmag;
      logic signed [CoordW-1:0] b;
      logic signed [ProdW-1:0]  exb;
      logic signed [ProdW-1:0]  eyc;
      logic signed [ProdW-1:0]  eyb;
      logic signed [ProdW-1:0]  exc;
      logic [3:0][SumW-1:0]     nsum;
      logic [3:0]               pneg;
   } meta_type;

   function automatic logic [CoordW-1:0] sat_coord(input logic [SatW-1:0] v);
      logic [CoordW-1:0] res;
      if (v[SatW-1:CoordW-1] == '0 || v[SatW-1:CoordW-1] == '1) begin
         res = v[CoordW-1:0];
      end else if (v[SatW-1]) begin
         res = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
         res = {1'b0, {(CoordW-1){1'b1}}};
      end
      return res;
   endfunction

   logic                 adv;
   logic [TolW-1:0]      tol_ff;
   logic [PipeDepth-1:0] vld_ff;

   meta_type s1_in, s1_ff, s2_in, s2_ff, s3_in, s3_ff, s4_in, s4_ff;
   meta_type s5_in, s5_ff, s6_in, s6_ff, s7_in, s7_ff, s8_in, s8_ff;
   meta_type s9_in, s9_ff, s10_in, s10_ff, s11_in, s11_ff;
   meta_type ma_ff [RootW];
   meta_type mb_ff [DivQW];
   meta_type mc_ff [RootW];
   meta_type md_ff [DivQW];

   root_cell_type ra [RootW+1];
   root_cell_type rc [RootW+1];
   div_cell_type  divb_in, divb_ff;
   div_cell_type  db [DivQW+1];
   div_cell_type  divd_in [4];
   div_cell_type  divd_ff [4];
   div_cell_type  dd [4][DivQW+1];

   logic [RspW-1:0] rsp_in, rsp_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[PipeDepth-1];
   assign rsp_tdata  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PipeDepth-2:0], req_tvalid};
      end
   end

   // differences and magnitudes
   always_comb begin
      logic signed [CoordW-1:0] x2;
      logic signed [CoordW-1:0] y2;
      s1_in    = '0;
      s1_in.x1 = req_tdata[23:0];
      s1_in.y1 = req_tdata[47:24];
      s1_in.r1 = req_tdata[70:48];
      x2       = req_tdata[94:71];
      y2       = req_tdata[118:95];
      s1_in.r2 = req_tdata[141:119];
      s1_in.ex = DiffW'(s1_in.x1) - DiffW'(x2);
      s1_in.ey = DiffW'(s1_in.y1) - DiffW'(y2);
      s1_in.ax = s1_in.ex[DiffW-1] ? DiffW'(-s1_in.ex) : s1_in.ex;
      s1_in.ay = s1_in.ey[DiffW-1] ? DiffW'(-s1_in.ey) : s1_in.ey;
      s1_in.rs = {1'b0, s1_in.r1} + {1'b0, s1_in.r2};
      s1_in.rd = (s1_in.r1 > s1_in.r2) ? s1_in.r1 - s1_in.r2 : s1_in.r2 - s1_in.r1;
      s1_in.same = (s1_in.r1 == s1_in.r2) && (s1_in.x1 == x2) && (s1_in.y1 == y2);
   end

   // squares
   always_comb begin
      s2_in          = s1_ff;
      s2_in.axx      = s1_ff.ax * s1_ff.ax;
      s2_in.ayy      = s1_ff.ay * s1_ff.ay;
      s2_in.big_sq   = s1_ff.rs * s1_ff.rs;
      s2_in.small_sq = s1_ff.rd * s1_ff.rd;
      s2_in.r1sq     = s1_ff.r1 * s1_ff.r1;
      s2_in.r2sq     = s1_ff.r2 * s1_ff.r2;
   end

   always_comb begin
      s3_in   = s2_ff;
      s3_in.d = s2_ff.axx + s2_ff.ayy;
   end

   // classification
   always_comb begin
      logic [SqW:0] dt;
      logic [SqW:0] st;
      s4_in = s3_ff;
      dt    = {1'b0, s3_ff.d} + (SqW+1)'(tol_ff);
      st    = (SqW+1)'(s3_ff.small_sq) + (SqW+1)'(tol_ff);
      if (s3_ff.same) begin
         s4_in.rel = REL_SAME;
      end else if (s3_ff.d > SqW'(s3_ff.big_sq)) begin
         s4_in.rel = REL_APART;
      end else if ((SqW+1)'(s3_ff.big_sq) <= dt) begin
         s4_in.rel = REL_EXT_TOUCH;
      end else if ({1'b0, s3_ff.d} > st) begin
         s4_in.rel = REL_TWO_POINTS;
      end else if ((SqW+1)'(s3_ff.small_sq) <= dt) begin
         s4_in.rel = REL_INT_TOUCH;
      end else begin
         s4_in.rel = REL_CONTAINED;
      end
      s4_in.inner = s3_ff.r1 < s3_ff.r2;
      s4_in.num   = $signed(NumW'(s3_ff.r1sq) + NumW'(s3_ff.d) - NumW'(s3_ff.r2sq));
   end

   assign ra[0] = '{arg: s4_ff.d, rem: '0, root: '0};

   // distance known, set up the chord offset division
   always_comb begin
      logic [NumW-1:0] mag;
      logic [NumW-1:0] adj;
      s5_in    = ma_ff[RootW-1];
      s5_in.sd = ra[RootW].root;
      mag = s5_in.num[NumW-1] ? NumW'(-s5_in.num) : NumW'(s5_in.num);
      adj = mag + NumW'(s5_in.sd);
      divb_in.rem = adj[NumW-1 -: DivDenW];
      divb_in.lo  = adj[DivQW-1:0];
      divb_in.den = {s5_in.sd, 1'b0};
   end

   assign db[0] = divb_ff;

   // clamp offset, or take the radius for a touch
   always_comb begin
      logic [DivQW-1:0] q;
      logic [RadW-1:0]  qmag;
      logic             neg;
      s6_in = mb_ff[DivQW-1];
      q     = db[DivQW].lo;
      qmag  = (q > DivQW'(s6_in.r1)) ? s6_in.r1 : q[RadW-1:0];
      neg   = s6_in.num[NumW-1];
      case (s6_in.rel)
         REL_EXT_TOUCH: begin
            qmag = s6_in.r1;
            neg  = 1'b0;
         end
         REL_INT_TOUCH: begin
            qmag = s6_in.r1;
            neg  = s6_in.inner;
         end
         default: begin
         end
      endcase
      s6_in.bmag = qmag;
      s6_in.b    = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
   end

   always_comb begin
      s7_in     = s6_ff;
      s7_in.bsq = s6_ff.bmag * s6_ff.bmag;
   end

   always_comb begin
      s8_in      = s7_ff;
      s8_in.carg = s7_ff.r1sq - s7_ff.bsq;
   end

   assign rc[0] = '{arg: RootArgW'(s8_ff.carg), rem: '0, root: '0};

   // half chord known, form the rotated products
   always_comb begin
      logic signed [CoordW-1:0] cs;
      s9_in     = mc_ff[RootW-1];
      cs        = $signed({1'b0, rc[RootW].root[RadW-1:0]});
      s9_in.exb = s9_in.ex * s9_in.b;
      s9_in.eyc = s9_in.ey * cs;
      s9_in.eyb = s9_in.ey * s9_in.b;
      s9_in.exc = s9_in.ex * cs;
   end

   always_comb begin
      s10_in         = s9_ff;
      s10_in.nsum[0] = SumW'(s9_ff.exb) + SumW'(s9_ff.eyc);
      s10_in.nsum[1] = SumW'(s9_ff.eyb) - SumW'(s9_ff.exc);
      s10_in.nsum[2] = SumW'(s9_ff.exb) - SumW'(s9_ff.eyc);
      s10_in.nsum[3] = SumW'(s9_ff.eyb) + SumW'(s9_ff.exc);
   end

   // magnitudes with rounding for the four point divisions
   always_comb begin
      logic [SumW-1:0] mag;
      logic [NumW-1:0] adj;
      s11_in = s10_ff;
      for (int i = 0; i < 4; i++) begin
         s11_in.pneg[i] = s10_ff.nsum[i][SumW-1];
         mag = s10_ff.nsum[i][SumW-1] ? SumW'(-$signed(s10_ff.nsum[i])) : s10_ff.nsum[i];
         adj = NumW'(mag) + NumW'(s10_ff.sd[RootW-1:1]);
         divd_in[i].rem = adj[NumW-1 -: DivDenW];
         divd_in[i].lo  = adj[DivQW-1:0];
         divd_in[i].den = DivDenW'(s10_ff.sd);
      end
   end

   // final points, saturation and field selection
   always_comb begin
      meta_type              md;
      logic [3:0][CoordW-1:0] pt;
      logic signed [SatW-1:0] qs;
      logic signed [SatW-1:0] base;
      md = md_ff[DivQW-1];
      for (int i = 0; i < 4; i++) begin
         qs    = $signed(SatW'(dd[i][DivQW].lo));
         if (md.pneg[i]) begin
            qs = -qs;
         end
         base  = (i % 2 == 0) ? SatW'(md.x1) : SatW'(md.y1);
         pt[i] = sat_coord(SatW'(base - qs));
      end
      if (md.sd == '0) begin
         pt[0] = sat_coord(SatW'(md.x1) + SatW'(md.b));
         pt[1] = md.y1;
      end
      case (md.rel)
         REL_TWO_POINTS: begin
         end
         REL_EXT_TOUCH, REL_INT_TOUCH: begin
            pt[2] = '0;
            pt[3] = '0;
         end
         default: begin
            pt = '0;
         end
      endcase
      rsp_in = {(RspW-RelW-4*CoordW)'(0), pt[3], pt[2], pt[1], pt[0], md.rel};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         s3_ff   <= s3_in;
         s4_ff   <= s4_in;
         s5_ff   <= s5_in;
         divb_ff <= divb_in;
         s6_ff   <= s6_in;
         s7_ff   <= s7_in;
         s8_ff   <= s8_in;
         s9_ff   <= s9_in;
         s10_ff  <= s10_in;
         s11_ff  <= s11_in;
         for (int i = 0; i < 4; i++) begin
            divd_ff[i] <= divd_in[i];
         end
         rsp_ff  <= rsp_in;
         ma_ff[0] <= s4_ff;
         mb_ff[0] <= s5_ff;
         mc_ff[0] <= s8_ff;
         md_ff[0] <= s11_ff;
         for (int k = 1; k < RootW; k++) begin
            ma_ff[k] <= ma_ff[k-1];
            mc_ff[k] <= mc_ff[k-1];
         end
         for (int k = 1; k < DivQW; k++) begin
            mb_ff[k] <= mb_ff[k-1];
            md_ff[k] <= md_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < RootW; k++) begin : g_root
      cpi_root_cell u_dist_cell (
         .clock  (clock),
         .enable (adv),
         .prev   (ra[k]),
         .next   (ra[k+1])
      );
      cpi_root_cell u_chord_cell (
         .clock  (clock),
         .enable (adv),
         .prev   (rc[k]),
         .next   (rc[k+1])
      );
   end

   for (genvar k = 0; k < DivQW; k++) begin : g_div
      cpi_div_cell u_offset_cell (
         .clock  (clock),
         .enable (adv),
         .prev   (db[k]),
         .next   (db[k+1])
      );
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      assign dd[i][0] = divd_ff[i];
      for (genvar k = 0; k < DivQW; k++) begin : g_cell
         cpi_div_cell u_point_cell (
            .clock  (clock),
            .enable (adv),
            .prev   (dd[i][k]),
            .next   (dd[i][k+1])
         );
      end
   end

endmodule

`default_nettype wire

// File: src/cpi_root_cell.sv
// cpi_root_cell: one digit step of the integer square root chain
// depends on cpi_pkg
`default_nettype none

module cpi_root_cell (
   input  logic                   clock,
   input  logic                   enable,
   input  cpi_pkg::root_cell_type prev,
   output cpi_pkg::root_cell_type next
);
   import cpi_pkg::*;

   logic [RootRemW+1:0] remx;
   logic [RootRemW+1:0] trial;
   logic [RootRemW+1:0] diff;
   logic                fits;
   root_cell_type       next_in;
   root_cell_type       next_ff;

   always_comb begin
      remx  = {prev.rem, prev.arg[RootArgW-1 -: 2]};
      trial = (RootRemW+2)'({prev.root, 2'b01});
      diff  = remx - trial;
      fits  = remx >= trial;
      next_in.arg  = {prev.arg[RootArgW-3:0], 2'b00};
      next_in.rem  = fits ? diff[RootRemW-1:0] : remx[RootRemW-1:0];
      next_in.root = {prev.root[RootW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         next_ff <= next_in;
      end
   end

   assign next = next_ff;

endmodule

`default_nettype wire

// File: src/cpi_div_cell.sv
// cpi_div_cell: one quotient bit of the restoring divider chain
// depends on cpi_pkg
`default_nettype none

module cpi_div_cell (
   input  logic                  clock,
   input  logic                  enable,
   input  cpi_pkg::div_cell_type prev,
   output cpi_pkg::div_cell_type next
);
   import cpi_pkg::*;

   logic [DivDenW:0] remx;
   logic [DivDenW:0] diff;
   logic             fits;
   div_cell_type     next_in;
   div_cell_type     next_ff;

   always_comb begin
      remx = {prev.rem, prev.lo[DivQW-1]};
      diff = remx - {1'b0, prev.den};
      fits = remx >= {1'b0, prev.den};
      next_in.rem = fits ? diff[DivDenW-1:0] : remx[DivDenW-1:0];
      next_in.lo  = {prev.lo[DivQW-2:0], fits};
      next_in.den = prev.den;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         next_ff <= next_in;
      end
   end

   assign next = next_ff;

endmodule

`default_nettype wire
